// File: design/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ddo_pkg.sv
// package: types, constants and tables of the odometry core
`default_nettype none
package ddo_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int C_TABLE_LEN       = 24;
    localparam int C_ROT_COUNT       = (CORDIC_ITERATIONS > C_TABLE_LEN) ?
                                       C_TABLE_LEN : CORDIC_ITERATIONS;
    localparam int C_CNT_W           = $clog2(C_TABLE_LEN);

    // register indexes of the configuration port
    localparam logic C_REG_SAMPLE_PERIOD = 1'b0;
    localparam logic C_REG_WHEEL_BASE_INV = 1'b1;

    localparam logic [15:0] C_PERIOD_RESET  = 16'd655;
    localparam logic [15:0] C_WBI_RESET     = 16'd1707;

    localparam logic signed [15:0] C_LEFT_WEIGHT = 16'sd19169;
    // 0.8 share doubled, and 0.2 share, both Q0.16
    localparam logic [32:0] C_GYRO_K  = 33'd104858;
    localparam logic [29:0] C_WHEEL_K = 30'd13107;

    localparam logic signed [19:0] C_HEADING_LIMIT = 20'sd25723;
    localparam logic signed [19:0] C_HEADING_STEP  = 20'sd51446;
    localparam logic signed [28:0] C_INC_LIMIT     = 29'sd131072;

    localparam logic signed [33:0] C_PI      = 34'sd3373259426;
    localparam logic signed [33:0] C_HALF_PI = 34'sd1686629713;
    localparam logic signed [33:0] C_GAIN    = 34'sd652032874;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_ROT,
        ST_MUL5,
        ST_MUL6,
        ST_UPD,
        ST_WRAP
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic mul3;
        logic mul4;
        logic rot_step;
        logic mul5;
        logic mul6;
        logic update;
        logic wrap_step;
        logic commit;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic rot_done;
        logic wrap_done;
        logic out_free;
    } t_dp_status;

    // arctangent of 2^-i in Q.30
    function automatic logic signed [33:0] atan_q30(input logic [C_CNT_W-1:0] idx);
        logic signed [33:0] r;
        case (idx)
            5'd0:  r = 34'sd843314856;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043836;
            5'd3:  r = 34'sd133525158;
            5'd4:  r = 34'sd67021686;
            5'd5:  r = 34'sd33543515;
            5'd6:  r = 34'sd16775850;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194282;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/ddo_ctrl.sv
// controller: sequences the steps of one odometry update
`default_nettype none
module ddo_ctrl
    import ddo_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MUL1;
            end
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_MUL3;
            ST_MUL3: n_state = ST_MUL4;
            ST_MUL4: n_state = ST_ROT;
            ST_ROT: begin
                if (i_status.rot_done) n_state = ST_MUL5;
            end
            ST_MUL5: n_state = ST_MUL6;
            ST_MUL6: n_state = ST_UPD;
            ST_UPD:  n_state = ST_WRAP;
            ST_WRAP: begin
                if (i_status.wrap_done && i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL1: o_cmd.mul1     = 1'b1;
            ST_MUL2: o_cmd.mul2     = 1'b1;
            ST_MUL3: o_cmd.mul3     = 1'b1;
            ST_MUL4: o_cmd.mul4     = 1'b1;
            ST_ROT:  o_cmd.rot_step = 1'b1;
            ST_MUL5: o_cmd.mul5     = 1'b1;
            ST_MUL6: o_cmd.mul6     = 1'b1;
            ST_UPD:  o_cmd.update   = 1'b1;
            ST_WRAP: begin
                o_cmd.wrap_step = !i_status.wrap_done;
                o_cmd.commit    = i_status.wrap_done && i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: design/ddo_datapath.sv
// datapath: speed, turn rate, cordic, pose state and result register
`default_nettype none
module ddo_datapath
    import ddo_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic signed [15:0] i_left_wheel_speed,
    input  wire logic signed [15:0] i_right_wheel_speed,
    input  wire logic signed [15:0] i_gyro_yaw_rate,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_status              o_status,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic signed [31:0]      o_pose_x,
    output logic signed [31:0]      o_pose_y,
    output logic signed [15:0]      o_pose_heading
);

    logic [15:0]        r_period;
    logic [15:0]        r_wbi;
    logic signed [31:0] r_pos_x;
    logic signed [31:0] r_pos_y;
    logic signed [15:0] r_heading;

    logic signed [15:0] r_vl, r_vr, r_gz;
    logic signed [31:0] r_wl;
    logic [32:0]        r_kg;
    logic [29:0]        r_kw;
    logic signed [21:0] r_v;
    logic signed [49:0] r_om_prod;
    logic signed [28:0] r_om;
    logic signed [49:0] r_gterm;
    logic signed [59:0] r_wterm;
    logic signed [33:0] r_x, r_y, r_z;
    logic               r_flip;
    logic [C_CNT_W-1:0] r_cnt;
    logic signed [55:0] r_px, r_py;
    logic signed [42:0] r_mx, r_my;
    logic signed [19:0] r_th;
    logic               r_out_valid;
    logic signed [31:0] r_out_x, r_out_y;
    logic signed [15:0] r_out_h;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= C_PERIOD_RESET;
            r_wbi    <= C_WBI_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                C_REG_SAMPLE_PERIOD:  r_period <= i_cfg_data;
                C_REG_WHEEL_BASE_INV: r_wbi    <= i_cfg_data;
                default: r_period <= r_period;
            endcase
        end
    end

    // speed and turn rate terms
    logic signed [31:0] wl_full;
    logic [32:0]        kg_full;
    logic [29:0]        kw_full;
    logic signed [32:0] vr14;
    logic signed [32:0] v_sum;
    logic signed [32:0] diff;
    logic signed [49:0] om_prod;
    logic signed [49:0] om_sum;
    logic signed [49:0] gterm;
    logic signed [59:0] wterm;

    assign wl_full = r_vl * C_LEFT_WEIGHT;
    assign kg_full = 33'(r_period) * C_GYRO_K;
    assign kw_full = 30'(r_period) * C_WHEEL_K;
    assign vr14    = $signed({{3{r_vr[15]}}, r_vr, 14'b0});
    assign v_sum   = vr14 + 33'(r_wl) + 33'sd1024;
    assign diff    = vr14 - 33'(r_wl);
    assign om_prod = diff * $signed({1'b0, r_wbi});
    assign om_sum  = r_om_prod + 50'sd1048576;
    assign gterm   = r_gz * $signed({1'b0, r_kg});
    assign wterm   = r_om * $signed({1'b0, r_kw});

    // cordic fold of the old heading
    logic signed [33:0] z0;
    logic signed [33:0] z_fold;
    logic               flip0;

    always_comb begin
        z0     = $signed({r_heading, 18'b0}) >>> 1;
        z_fold = z0;
        flip0  = 1'b0;
        if (z0 > C_HALF_PI) begin
            z_fold = z0 - C_PI;
            flip0  = 1'b1;
        end else if (z0 < -C_HALF_PI) begin
            z_fold = z0 + C_PI;
            flip0  = 1'b1;
        end
    end

    // one cordic micro-rotation
    logic signed [33:0] x_sh, y_sh, atan_i;
    assign x_sh   = r_x >>> r_cnt;
    assign y_sh   = r_y >>> r_cnt;
    assign atan_i = atan_q30(r_cnt);

    // position products
    logic signed [33:0] cos_v, sin_v;
    logic signed [55:0] px_sum, py_sum;
    logic signed [25:0] px_r, py_r;
    logic signed [42:0] mx, my;

    assign cos_v  = r_flip ? -r_x : r_x;
    assign sin_v  = r_flip ? -r_y : r_y;
    assign px_sum = r_px + 56'sd536870912;
    assign py_sum = r_py + 56'sd536870912;
    assign px_r   = 26'(px_sum >>> 30);
    assign py_r   = 26'(py_sum >>> 30);
    assign mx     = px_r * $signed({1'b0, r_period});
    assign my     = py_r * $signed({1'b0, r_period});

    // position update with saturation
    logic signed [42:0] mx_sum, my_sum;
    logic signed [32:0] nx_sum, ny_sum;
    logic signed [31:0] nx_sat, ny_sat;

    assign mx_sum = r_mx + 43'sd32768;
    assign my_sum = r_my + 43'sd32768;
    assign nx_sum = 33'(r_pos_x) + 33'(mx_sum >>> 16);
    assign ny_sum = 33'(r_pos_y) + 33'(my_sum >>> 16);

    always_comb begin
        nx_sat = nx_sum[31:0];
        ny_sat = ny_sum[31:0];
        if (nx_sum[32] != nx_sum[31]) nx_sat = nx_sum[32] ? 32'sh80000000 : 32'sh7fffffff;
        if (ny_sum[32] != ny_sum[31]) ny_sat = ny_sum[32] ? 32'sh80000000 : 32'sh7fffffff;
    end

    // heading increment, limited to +-16 rad
    logic signed [60:0] inc_sum;
    logic signed [28:0] inc_full;
    logic signed [28:0] inc_sat;

    assign inc_sum  = 61'(r_gterm) + 61'(r_wterm) + 61'sd2147483648;
    assign inc_full = 29'(inc_sum >>> 32);

    always_comb begin
        inc_sat = inc_full;
        if (inc_full > C_INC_LIMIT)  inc_sat = C_INC_LIMIT;
        if (inc_full < -C_INC_LIMIT) inc_sat = -C_INC_LIMIT;
    end

    // working registers of one item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vl   <= i_left_wheel_speed;
            r_vr   <= i_right_wheel_speed;
            r_gz   <= i_gyro_yaw_rate;
            r_x    <= C_GAIN;
            r_y    <= '0;
            r_z    <= z_fold;
            r_flip <= flip0;
        end
        if (i_cmd.mul1) begin
            r_wl <= wl_full;
            r_kg <= kg_full;
            r_kw <= kw_full;
        end
        if (i_cmd.mul2) begin
            r_v       <= 22'(v_sum >>> 11);
            r_om_prod <= om_prod;
        end
        if (i_cmd.mul3) begin
            r_om    <= 29'(om_sum >>> 21);
            r_gterm <= gterm;
        end
        if (i_cmd.mul4) begin
            r_wterm <= wterm;
        end
        if (i_cmd.rot_step) begin
            if (r_z >= 0) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_i;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_i;
            end
        end
        if (i_cmd.mul5) begin
            r_px <= r_v * cos_v;
            r_py <= r_v * sin_v;
        end
        if (i_cmd.mul6) begin
            r_mx <= mx;
            r_my <= my;
        end
        if (i_cmd.update) begin
            r_th <= 20'(r_heading) + 20'(inc_sat);
        end else if (i_cmd.wrap_step) begin
            if (r_th > C_HEADING_LIMIT) r_th <= r_th - C_HEADING_STEP;
            else                        r_th <= r_th + C_HEADING_STEP;
        end
    end

    // rotation counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.rot_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= '0;
        end else begin
            if (i_cmd.update) begin
                r_pos_x <= nx_sat;
                r_pos_y <= ny_sat;
            end
            if (i_cmd.commit) r_heading <= 16'(r_th);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_x <= r_pos_x;
            r_out_y <= r_pos_y;
            r_out_h <= 16'(r_th);
        end
    end

    // status
    assign o_status.rot_done  = (r_cnt == C_CNT_W'(C_ROT_COUNT - 1));
    assign o_status.wrap_done = (r_th <= C_HEADING_LIMIT) && (r_th >= -C_HEADING_LIMIT);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_pose_x       = r_out_x;
    assign o_pose_y       = r_out_y;
    assign o_pose_heading = r_out_h;

endmodule
`default_nettype wire

// File: design/differential_drive_odometry_core.sv
// top level: differential drive odometry core
//
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_ready   wheel speeds, gyro yaw rate
// result    out        o_out_valid / i_out_ready pose x, pose y, heading
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// one item at a time: an accept step, 4 multiply steps, CORDIC_ITERATIONS
// rotation steps, 2 position multiply steps, one update and then the heading
// wrap steps and the commit in the wrap state
// the result register lets the next item enter while the result waits
// a stalled result holds the last wrap step until the register frees
// synchronous reset clears pose to zero and loads the default registers
`default_nettype none
`include "assert_macros.svh"
module differential_drive_odometry_core
    import ddo_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_left_wheel_speed,
    input  wire logic signed [15:0] i_right_wheel_speed,
    input  wire logic signed [15:0] i_gyro_yaw_rate,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_pose_x,
    output logic signed [31:0]      o_pose_y,
    output logic signed [15:0]      o_pose_heading
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer
    ddo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // arithmetic and state
    ddo_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_left_wheel_speed  (i_left_wheel_speed),
        .i_right_wheel_speed (i_right_wheel_speed),
        .i_gyro_yaw_rate     (i_gyro_yaw_rate),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_pose_x            (o_pose_x),
        .o_pose_y            (o_pose_y),
        .o_pose_heading      (o_pose_heading)
    );

    // checks
    `ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `ASSERT_SAME(a_heading_range, o_out_valid, (o_pose_heading <= 16'sd25723) && (o_pose_heading >= -16'sd25723), "heading out of range")
    `ASSERT_SAME(a_commit_wrapped, cmd.commit, status.wrap_done && status.out_free, "commit before wrap")

endmodule
`default_nettype wire
